### rtl/ial_pkg.sv
package ial_pkg;

    // Table geometry.
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 11;
    localparam int CMD_W    = 3;
    localparam int SPAN_W   = DATA_W + 1;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RANGE_ALL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RANGE_ANY = 3'd4;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    // Entry memory write port.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } ram_wr_t;

    // Entry memory read request.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ram_rd_t;

endpackage

### rtl/ial_ram.sv
module ial_ram import ial_pkg::*; (
    input  logic              aclk,
    input  ram_wr_t           wr,
    input  ram_rd_t           rd,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [CAPACITY];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

### rtl/ipv4_address_list_table.sv
// Channel  | Direction | Ports                                   | Handshake
// ---------+-----------+-----------------------------------------+----------------
// input    | in        | s_cmd, s_address, s_range_end           | s_valid/s_ready
// result   | out       | m_position, m_answer, m_dropped         | m_valid/m_ready
//
// One item is worked at a time; the memory's single read port scans one entry a cycle.
// Reset clears the entry count but not the entry memory, so no clearing pass is needed after reset.
// A result waits in the output register; s_ready rises again once it is stored there.
module ipv4_address_list_table import ial_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CMD_W-1:0]  s_cmd,
    input  logic [DATA_W-1:0] s_address,
    input  logic [DATA_W-1:0] s_range_end,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [POS_W-1:0]  m_position,
    output logic              m_answer,
    output logic              m_dropped
);

    state_t              state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [DATA_W-1:0]   addr_reg, addr_next;
    logic [DATA_W-1:0]   lo_reg, lo_next;
    logic [DATA_W-1:0]   hi_reg, hi_next;
    logic [SPAN_W-1:0]   span_reg, span_next;
    logic [COUNT_W-1:0]  idx_reg, idx_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [COUNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  hits_reg, hits_next;
    logic [POS_W-1:0]    res_position_reg, res_position_next;
    logic                res_answer_reg, res_answer_next;
    logic                res_dropped_reg, res_dropped_next;
    logic                m_valid_reg, m_valid_next;
    logic [POS_W-1:0]    m_position_reg, m_position_next;
    logic                m_answer_reg, m_answer_next;
    logic                m_dropped_reg, m_dropped_next;

    ram_wr_t             wr;
    ram_rd_t             rd;
    logic [DATA_W-1:0]   rd_data;
    logic [COUNT_W-1:0]  shift_waddr;

    logic                is_lookup;
    logic                is_range;
    logic                issue;
    logic                match;
    logic                in_range;
    logic                scan_end;
    logic                shift_end;
    logic                out_free;

    ial_ram u_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    // Command class and scan pipeline control.
    assign is_lookup = (cmd_reg == CMD_INSERT) || (cmd_reg == CMD_REMOVE) ||
                       (cmd_reg == CMD_SEARCH);
    assign is_range  = (cmd_reg == CMD_RANGE_ALL) || (cmd_reg == CMD_RANGE_ANY);
    assign issue     = ((state_reg == ST_SCAN) || (state_reg == ST_SHIFT)) &&
                       (idx_reg < count_reg);
    assign match     = (state_reg == ST_SCAN) && rd_pend_reg && is_lookup &&
                       (rd_data == addr_reg);
    assign in_range  = (rd_data >= lo_reg) && (rd_data <= hi_reg);
    assign scan_end  = (state_reg == ST_SCAN) && !match && !issue && !rd_pend_reg;
    assign shift_end = (state_reg == ST_SHIFT) && !issue && !rd_pend_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign shift_waddr = rd_idx_reg - COUNT_W'(1);

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_position = m_position_reg;
    assign m_answer   = m_answer_reg;
    assign m_dropped  = m_dropped_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if ((s_cmd == CMD_RANGE_ALL) || (s_cmd == CMD_RANGE_ANY)) begin
                        state_next = ST_SETUP;
                    end else if ((s_cmd == CMD_INSERT) || (s_cmd == CMD_REMOVE) ||
                                 (s_cmd == CMD_SEARCH)) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SETUP: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (match) begin
                    state_next = (cmd_reg == CMD_REMOVE) ? ST_SHIFT : ST_DONE;
                end else if (scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (shift_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory ports and result register.
    always_comb begin
        cmd_next          = cmd_reg;
        addr_next         = addr_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        span_next         = span_reg;
        idx_next          = idx_reg;
        rd_pend_next      = issue;
        rd_idx_next       = rd_idx_reg;
        count_next        = count_reg;
        hits_next         = hits_reg;
        res_position_next = res_position_reg;
        res_answer_next   = res_answer_reg;
        res_dropped_next  = res_dropped_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_position_next   = m_position_reg;
        m_answer_next     = m_answer_reg;
        m_dropped_next    = m_dropped_reg;

        wr.en   = 1'b0;
        wr.addr = count_reg[ADDR_W-1:0];
        wr.data = addr_reg;
        rd.en   = issue;
        rd.addr = idx_reg[ADDR_W-1:0];

        if (issue) begin
            idx_next    = idx_reg + COUNT_W'(1);
            rd_idx_next = idx_reg;
        end

        case (state_reg)
            ST_IDLE: begin
                // Capture the item and put the range ends in order.
                if (s_valid) begin
                    cmd_next          = s_cmd;
                    addr_next         = s_address;
                    lo_next           = (s_address <= s_range_end) ? s_address : s_range_end;
                    hi_next           = (s_address <= s_range_end) ? s_range_end : s_address;
                    idx_next          = '0;
                    hits_next         = '0;
                    res_position_next = '0;
                    res_answer_next   = 1'b0;
                    res_dropped_next  = 1'b0;
                end
            end
            ST_SETUP: begin
                span_next = {1'b0, hi_reg} - {1'b0, lo_reg} + SPAN_W'(1);
            end
            ST_SCAN: begin
                // Count entries inside the range as they come out of memory.
                if (rd_pend_reg && is_range && in_range) begin
                    hits_next = hits_reg + COUNT_W'(1);
                end
                if (match) begin
                    if (cmd_reg == CMD_SEARCH) begin
                        res_position_next = POS_W'(rd_idx_reg + COUNT_W'(1));
                        res_answer_next   = 1'b1;
                    end
                end else if (scan_end) begin
                    case (cmd_reg)
                        CMD_INSERT: begin
                            if (count_reg < COUNT_W'(CAPACITY)) begin
                                wr.en      = 1'b1;
                                count_next = count_reg + COUNT_W'(1);
                            end else begin
                                res_dropped_next = 1'b1;
                            end
                        end
                        CMD_RANGE_ALL: begin
                            res_answer_next = (SPAN_W'(hits_reg) == span_reg);
                        end
                        CMD_RANGE_ANY: begin
                            res_answer_next = (hits_reg != '0);
                        end
                        default: begin
                            res_answer_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                // Move each later entry down by one place.
                if (rd_pend_reg) begin
                    wr.en   = 1'b1;
                    wr.addr = shift_waddr[ADDR_W-1:0];
                    wr.data = rd_data;
                end
                if (shift_end) begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_position_next = res_position_reg;
                    m_answer_next   = res_answer_reg;
                    m_dropped_next  = res_dropped_reg;
                end
            end
            default: begin
                rd_pend_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg          <= cmd_next;
        addr_reg         <= addr_next;
        lo_reg           <= lo_next;
        hi_reg           <= hi_next;
        span_reg         <= span_next;
        idx_reg          <= idx_next;
        rd_idx_reg       <= rd_idx_next;
        hits_reg         <= hits_next;
        res_position_reg <= res_position_next;
        res_answer_reg   <= res_answer_next;
        res_dropped_reg  <= res_dropped_next;
        m_position_reg   <= m_position_next;
        m_answer_reg     <= m_answer_next;
        m_dropped_reg    <= m_dropped_next;
    end

    // The shift never writes the entry it is reading in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.en && rd.en) |-> (wr.addr != rd.addr))
        else $error("entry memory read and write collide");

    // The fill count never passes the capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A pending read always refers to a filled entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (rd_idx_reg < count_reg))
        else $error("read of an entry beyond the fill count");

    // A finished remove shrinks the table by exactly one entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        shift_end |=> (count_reg == $past(count_reg) - COUNT_W'(1)))
        else $error("remove did not shrink the table by one");

endmodule
